// File: sv/tacs_pkg.sv
// Shared types and constants for the thermal-aware core selector.
`timescale 1ns / 1ps

package tacs_pkg;

    // Number of cores and width of one queue depth entry.
    localparam int NUM_CORES  = 64;
    localparam int DEPTH_BITS = 16;
    localparam int CORE_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CNT_W      = 7;
    localparam int MASK_W     = 64;

    // Function codes of an input request.
    localparam logic [1:0] FUNC_CLASS  = 2'd0;
    localparam logic [1:0] FUNC_DEPTH  = 2'd1;
    localparam logic [1:0] FUNC_SELECT = 2'd2;

    // Thermal class codes.
    localparam logic [1:0] CLASS_COLD = 2'd0;
    localparam logic [1:0] CLASS_WARM = 2'd1;
    localparam logic [1:0] CLASS_HOT  = 2'd2;

    // Marker for no chosen core (-1 in seven bits).
    localparam logic [6:0] NO_CORE = 7'h7F;

    // Decision codes reported with each result.
    typedef enum logic [2:0] {
        DEC_RECENT   = 3'd0,
        DEC_PREVIOUS = 3'd1,
        DEC_COLDEST  = 3'd2,
        DEC_WARM     = 3'd3,
        DEC_NONE     = 3'd4,
        DEC_DISABLED = 3'd5,
        DEC_KERNEL   = 3'd6,
        DEC_UPDATE   = 3'd7
    } dec_t;

    // Write broadcast from the controller to every cell.
    typedef struct packed {
        logic                  class_we;
        logic                  depth_we;
        logic [CORE_W-1:0]     idx;
        logic [1:0]            cls;
        logic [DEPTH_BITS-1:0] depth;
    } upd_t;

    // Search context held steady for the whole scan.
    typedef struct packed {
        logic [6:0]       recent;
        logic [6:0]       prev;
        logic [CNT_W-1:0] n;
    } ctx_t;

    // Search wave handed from cell to cell.
    typedef struct packed {
        logic                  valid;
        logic [DEPTH_BITS-1:0] min_depth;
        logic [CORE_W-1:0]     best_idx;
        logic                  found;
        logic                  warm_seen;
        logic                  recent_ok;
        logic                  prev_ok;
    } wave_t;

endpackage

// File: sv/tacs_cell.sv
// One core cell: holds the core's class and depth and advances the search wave.
`timescale 1ns / 1ps

module tacs_cell
    import tacs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CORE_W-1:0] cell_id,
    input  logic              allow_bit,
    input  upd_t              upd,
    input  ctx_t              ctx,
    input  wave_t             wave_in,
    output wave_t             wave_out
);

    logic [1:0]            class_reg;
    logic [1:0]            class_next;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    wave_t                 wave_reg;
    wave_t                 wave_next;

    logic       hit;
    logic       allowed;
    logic       is_cold;
    logic       is_warm;
    logic [6:0] my_id;

    // Local state updates from the write broadcast.
    always_comb
    begin
        hit        = (upd.idx == cell_id);
        class_next = class_reg;
        depth_next = depth_reg;
        if (upd.class_we && hit)
        begin
            class_next = upd.cls;
        end
        if (upd.depth_we && hit)
        begin
            depth_next = upd.depth;
        end
    end

    // Fold this core into the passing wave.
    always_comb
    begin
        my_id     = 7'(cell_id);
        allowed   = allow_bit && (my_id < 7'(ctx.n));
        is_cold   = (class_reg == CLASS_COLD);
        is_warm   = (class_reg == CLASS_WARM);
        wave_next = wave_in;
        if (allowed && is_cold && (depth_reg < wave_in.min_depth))
        begin
            wave_next.min_depth = depth_reg;
            wave_next.best_idx  = cell_id;
            wave_next.found     = 1'b1;
        end
        if (allowed && is_warm)
        begin
            wave_next.warm_seen = 1'b1;
        end
        if (allowed && (is_cold || is_warm) && (ctx.recent == my_id))
        begin
            wave_next.recent_ok = 1'b1;
        end
        if (allowed && (is_cold || is_warm) && (ctx.prev == my_id))
        begin
            wave_next.prev_ok = 1'b1;
        end
    end

    // Core state resets to warm with an empty queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= CLASS_WARM;
            depth_reg <= '0;
        end
        else
        begin
            class_reg <= class_next;
            depth_reg <= depth_next;
        end
    end

    // The wave register resets empty, with no wave in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule

// File: sv/thermal_aware_core_selector_core.sv
// Top level of the thermal-aware core selector: controller and cell chain.
`timescale 1ns / 1ps

// Update requests (class or depth write), kernel-task selects and selects while the
// policy is disabled go straight from acceptance to the finish state. A full select
// first starts a search wave at the head of the chain of core cells; the wave crosses
// the chain one cell per clock, collecting the recent and previous core checks, the
// coldest allowed core and the warm flag as it goes, and its result is then held for
// the finish state. From the finish state a result moves into the output register
// once that register is free. One request is in work at a time; a new request is
// accepted while the previous result still waits in the output register, and its own
// result then waits until that one is taken. cpu_count may be written at any idle time;
// values above NUM_CORES act as NUM_CORES and zero disables the policy.

module thermal_aware_core_selector_core
    import tacs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [6:0]        cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [5:0]        core_index,
    input  logic [1:0]        thermal_class,
    input  logic [15:0]       depth_value,
    input  logic [63:0]       allow_mask,
    input  logic signed [6:0] previous_core,
    input  logic signed [6:0] recent_core,
    input  logic              kernel_task,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [6:0] chosen_core,
    output logic [2:0]        decision,
    output logic [63:0]       run_mask
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cpu_count_reg;
    logic [CNT_W-1:0]  cpu_count_next;
    logic              start_reg;
    logic              start_next;
    ctx_t              ctx_reg;
    ctx_t              ctx_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [6:0]        pend_core_reg;
    logic [6:0]        pend_core_next;
    dec_t              pend_dec_reg;
    dec_t              pend_dec_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [6:0]        out_core_reg;
    logic [6:0]        out_core_next;
    dec_t              out_dec_reg;
    dec_t              out_dec_next;
    logic [63:0]       out_mask_reg;
    logic [63:0]       out_mask_next;

    logic              accept;
    logic [CNT_W-1:0]  n_eff;
    upd_t              upd;
    wave_t             wave [NUM_CORES+1];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Effective core count, clipped to the cores that exist.
    assign n_eff = (cpu_count_reg > CNT_W'(NUM_CORES)) ? CNT_W'(NUM_CORES) : cpu_count_reg;

    // Configuration register.
    assign cpu_count_next = cfg_wr_en ? CNT_W'(cfg_wr_data) : cpu_count_reg;

    // Write broadcast for class and depth updates; class three stores as hot.
    always_comb
    begin
        upd.class_we = accept && (func == FUNC_CLASS) && (7'(core_index) < 7'(NUM_CORES));
        upd.depth_we = accept && (func == FUNC_DEPTH) && (7'(core_index) < 7'(NUM_CORES));
        upd.idx      = CORE_W'(core_index);
        upd.cls      = (thermal_class > CLASS_HOT) ? CLASS_HOT : thermal_class;
        upd.depth    = DEPTH_BITS'(depth_value);
    end

    // Wave injected at the head of the chain.
    always_comb
    begin
        wave[0].valid      = start_reg;
        wave[0].min_depth  = '1;
        wave[0].best_idx   = '0;
        wave[0].found      = 1'b0;
        wave[0].warm_seen  = 1'b0;
        wave[0].recent_ok  = 1'b0;
        wave[0].prev_ok    = 1'b0;
    end

    // Chain of core cells.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_CORES; gi++)
        begin : g_cell
            tacs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_id   (CORE_W'(gi)),
                .allow_bit (mask_reg[gi]),
                .upd       (upd),
                .ctx       (ctx_reg),
                .wave_in   (wave[gi]),
                .wave_out  (wave[gi+1])
            );
        end
    endgenerate

    // Controller: accept, scan for a full select, then hand the result to the output register.
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        ctx_next       = ctx_reg;
        mask_next      = mask_reg;
        pend_core_next = pend_core_reg;
        pend_dec_next  = pend_dec_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_core_next  = out_core_reg;
        out_dec_next   = out_dec_reg;
        out_mask_next  = out_mask_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_core_next = NO_CORE;
                    ctx_next.recent = recent_core;
                    ctx_next.prev   = previous_core;
                    ctx_next.n      = n_eff;
                    mask_next       = allow_mask;
                    if (func != FUNC_SELECT)
                    begin
                        pend_dec_next = DEC_UPDATE;
                        state_next    = ST_FINISH;
                    end
                    else if (kernel_task)
                    begin
                        pend_dec_next = DEC_KERNEL;
                        state_next    = ST_FINISH;
                    end
                    else if (n_eff == '0)
                    begin
                        pend_dec_next = DEC_DISABLED;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (wave[NUM_CORES].valid)
                begin
                    state_next = ST_FINISH;
                    if (wave[NUM_CORES].recent_ok)
                    begin
                        pend_core_next = ctx_reg.recent;
                        pend_dec_next  = DEC_RECENT;
                    end
                    else if (wave[NUM_CORES].prev_ok)
                    begin
                        pend_core_next = ctx_reg.prev;
                        pend_dec_next  = DEC_PREVIOUS;
                    end
                    else if (wave[NUM_CORES].found)
                    begin
                        pend_core_next = 7'(wave[NUM_CORES].best_idx);
                        pend_dec_next  = DEC_COLDEST;
                    end
                    else if (wave[NUM_CORES].warm_seen)
                    begin
                        pend_core_next = NO_CORE;
                        pend_dec_next  = DEC_WARM;
                    end
                    else
                    begin
                        pend_core_next = NO_CORE;
                        pend_dec_next  = DEC_NONE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_core_next  = pend_core_reg;
                    out_dec_next   = pend_dec_reg;
                    out_mask_next  = pend_core_reg[6] ? 64'd0
                                                      : (64'd1 << pend_core_reg[5:0]);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cpu_count_reg <= CNT_W'(64);
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cpu_count_reg <= cpu_count_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ctx_reg       <= ctx_next;
        mask_reg      <= mask_next;
        pend_core_reg <= pend_core_next;
        pend_dec_reg  <= pend_dec_next;
        out_core_reg  <= out_core_next;
        out_dec_reg   <= out_dec_next;
        out_mask_reg  <= out_mask_next;
    end

    assign out_valid   = out_valid_reg;
    assign chosen_core = out_core_reg;
    assign decision    = out_dec_reg;
    assign run_mask    = out_mask_reg;

    // An accepted request always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted request did not leave idle");

    // The search wave only leaves the chain while a scan is running.
    a_wave_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wave[NUM_CORES].valid |-> (state_reg == ST_SCAN))
        else $error("search wave exited outside a scan");

    // A presented result carries at most one pin bit.
    a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(out_mask_reg))
        else $error("pin mask is not one-hot");

    // No chosen core means an empty pin mask, and a chosen core sets exactly its bit.
    a_mask_matches_core: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_core_reg[6] ? (out_mask_reg == 64'd0)
                                           : $onehot(out_mask_reg)))
        else $error("pin mask does not match chosen core");

endmodule
